>>> design/upe_pkg.sv
package upe_pkg;

    // Largest number of bytes of one frame that the parser looks at
    localparam int MAX_FRAME_BYTES = 16384;

    // Header constants
    localparam logic [15:0] ETHERTYPE_VLAN = 16'h8100;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;
    localparam logic [3:0]  IP_VERSION_4   = 4'd4;
    localparam logic [3:0]  IHL_MIN_WORDS  = 4'd5;
    localparam int          ETH_HDR_BYTES  = 14;
    localparam logic [15:0] UDP_HDR_BYTES  = 16'd8;

    // Result status codes
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_SHORT        = 3'd1;
    localparam logic [2:0] ST_NOT_IPV4     = 3'd2;
    localparam logic [2:0] ST_BAD_VERSION  = 3'd3;
    localparam logic [2:0] ST_BAD_IHL      = 3'd4;
    localparam logic [2:0] ST_NOT_UDP      = 3'd5;
    localparam logic [2:0] ST_BAD_UDP_LEN  = 3'd6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
        logic       frame_end;
    } byte_beat_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       segment_last;
        logic [2:0] status;
    } result_beat_t;

endpackage

>>> design/upe_parser.sv
module upe_parser #(
    parameter int MAX_FRAME_BYTES = upe_pkg::MAX_FRAME_BYTES
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  upe_pkg::byte_beat_t      beat,
    output logic                     res_valid,
    output upe_pkg::result_beat_t    res
);

    localparam int OFF_W = $clog2(MAX_FRAME_BYTES + 1);
    // header end can reach the last offset plus a 60 byte IP header
    localparam int END_W = $clog2(MAX_FRAME_BYTES + 61);
    localparam int SUM_W = END_W + 1;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_ETH  = 3'd1;
    localparam logic [2:0] PH_VLAN = 3'd2;
    localparam logic [2:0] PH_IP   = 3'd3;
    localparam logic [2:0] PH_UDP  = 3'd4;
    localparam logic [2:0] PH_PAY  = 3'd5;
    localparam logic [2:0] PH_DONE = 3'd6;
    localparam logic [2:0] PH_REJ  = 3'd7;

    logic [2:0]       phase_reg,     phase_next;
    logic [OFF_W-1:0] offset_reg,    offset_next;
    logic [15:0]      shift_reg,     shift_next;
    logic [END_W-1:0] hdr_end_reg,   hdr_end_next;
    logic [15:0]      remaining_reg, remaining_next;
    logic [2:0]       reject_reg,    reject_next;

    always_comb
    begin
        logic             start;
        logic [2:0]       ph_cur;
        logic [OFF_W-1:0] off_cur;
        logic [15:0]      shift_cur;
        logic [END_W-1:0] hend_cur;
        logic [15:0]      rem_cur;
        logic [15:0]      shifted;
        logic [SUM_W-1:0] off_s;
        logic [SUM_W-1:0] hend_s;
        logic [SUM_W-1:0] ihl_s;

        phase_next     = phase_reg;
        offset_next    = offset_reg;
        shift_next     = shift_reg;
        hdr_end_next   = hdr_end_reg;
        remaining_next = remaining_reg;
        reject_next    = reject_reg;
        res_valid      = 1'b0;
        res            = '0;

        start     = beat.frame_start;
        ph_cur    = start ? PH_ETH : phase_reg;
        off_cur   = start ? '0 : offset_reg;
        shift_cur = start ? '0 : shift_reg;
        hend_cur  = start ? '0 : hdr_end_reg;
        rem_cur   = start ? '0 : remaining_reg;
        shifted   = {shift_cur[7:0], beat.data_byte};
        off_s     = {{(SUM_W - OFF_W){1'b0}}, off_cur};
        hend_s    = {1'b0, hend_cur};
        ihl_s     = SUM_W'({beat.data_byte[3:0], 2'b00});

        if (accept && (start || phase_reg != PH_IDLE))
        begin
            phase_next     = ph_cur;
            offset_next    = off_cur;
            shift_next     = shift_cur;
            hdr_end_next   = hend_cur;
            remaining_next = rem_cur;
            reject_next    = start ? upe_pkg::ST_OK : reject_reg;

            if (off_cur < OFF_W'(MAX_FRAME_BYTES))
            begin
                offset_next = off_cur + OFF_W'(1);
                case (ph_cur)
                    PH_ETH, PH_VLAN:
                    begin
                        shift_next = shifted;
                        if ((ph_cur == PH_ETH &&
                             off_cur == OFF_W'(upe_pkg::ETH_HDR_BYTES - 1)) ||
                            (ph_cur == PH_VLAN && off_s == hend_s + SUM_W'(3)))
                        begin
                            // ethertype complete: another tag, IPv4, or reject
                            if (shifted == upe_pkg::ETHERTYPE_VLAN)
                            begin
                                phase_next   = PH_VLAN;
                                hdr_end_next = END_W'(off_s + SUM_W'(1));
                            end
                            else if (shifted == upe_pkg::ETHERTYPE_IPV4)
                            begin
                                phase_next   = PH_IP;
                                hdr_end_next = END_W'(off_s + SUM_W'(1));
                                shift_next   = '0;
                            end
                            else
                            begin
                                phase_next  = PH_REJ;
                                reject_next = upe_pkg::ST_NOT_IPV4;
                            end
                        end
                    end
                    PH_IP:
                    begin
                        if (shift_cur == '0)
                        begin
                            // version / IHL byte; shift then holds header length
                            if (beat.data_byte[7:4] != upe_pkg::IP_VERSION_4)
                            begin
                                phase_next  = PH_REJ;
                                reject_next = upe_pkg::ST_BAD_VERSION;
                            end
                            else if (beat.data_byte[3:0] < upe_pkg::IHL_MIN_WORDS)
                            begin
                                phase_next  = PH_REJ;
                                reject_next = upe_pkg::ST_BAD_IHL;
                            end
                            else
                            begin
                                shift_next   = 16'(ihl_s);
                                hdr_end_next = END_W'(off_s + ihl_s);
                            end
                        end
                        else if (off_s + SUM_W'(shift_cur[5:0]) == hend_s + SUM_W'(9) &&
                                 beat.data_byte != upe_pkg::IP_PROTO_UDP)
                        begin
                            phase_next  = PH_REJ;
                            reject_next = upe_pkg::ST_NOT_UDP;
                        end
                        else if (off_s + SUM_W'(1) == hend_s)
                        begin
                            phase_next = PH_UDP;
                            shift_next = '0;
                        end
                    end
                    PH_UDP:
                    begin
                        shift_next = shifted;
                        if (off_s == hend_s + SUM_W'(5))
                        begin
                            remaining_next = shifted;
                        end
                        if (off_s == hend_s + SUM_W'(7))
                        begin
                            if (rem_cur < upe_pkg::UDP_HDR_BYTES)
                            begin
                                phase_next  = PH_REJ;
                                reject_next = upe_pkg::ST_BAD_UDP_LEN;
                            end
                            else if (rem_cur == upe_pkg::UDP_HDR_BYTES)
                            begin
                                remaining_next   = '0;
                                res_valid        = 1'b1;
                                res.segment_last = 1'b1;
                                phase_next       = PH_DONE;
                            end
                            else
                            begin
                                remaining_next = rem_cur - upe_pkg::UDP_HDR_BYTES;
                                phase_next     = PH_PAY;
                            end
                        end
                    end
                    PH_PAY:
                    begin
                        res_valid         = 1'b1;
                        res.payload_byte  = beat.data_byte;
                        res.payload_valid = 1'b1;
                        remaining_next    = rem_cur - 16'd1;
                        if (remaining_next == '0)
                        begin
                            res.segment_last = 1'b1;
                            phase_next       = PH_DONE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (beat.frame_end)
            begin
                if (res_valid)
                begin
                    res.segment_last = 1'b1;
                end
                else
                begin
                    case (phase_next)
                        PH_ETH, PH_IP, PH_UDP:
                        begin
                            res_valid        = 1'b1;
                            res.segment_last = 1'b1;
                            res.status       = upe_pkg::ST_SHORT;
                        end
                        PH_VLAN:
                        begin
                            res_valid        = 1'b1;
                            res.segment_last = 1'b1;
                            res.status       = upe_pkg::ST_NOT_IPV4;
                        end
                        PH_PAY:
                        begin
                            res_valid        = 1'b1;
                            res.segment_last = 1'b1;
                            res.status       = upe_pkg::ST_OK;
                        end
                        PH_REJ:
                        begin
                            res_valid        = 1'b1;
                            res.segment_last = 1'b1;
                            res.status       = reject_next;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                phase_next = PH_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            offset_reg    <= '0;
            shift_reg     <= '0;
            hdr_end_reg   <= '0;
            remaining_reg <= '0;
            reject_reg    <= upe_pkg::ST_OK;
        end
        else
        begin
            phase_reg     <= phase_next;
            offset_reg    <= offset_next;
            shift_reg     <= shift_next;
            hdr_end_reg   <= hdr_end_next;
            remaining_reg <= remaining_next;
            reject_reg    <= reject_next;
        end
    end

endmodule

>>> design/udp_payload_extractor.sv
// UDP payload extractor.
// Input channel (byte_valid / byte_stall / byte_data): one captured frame
// byte per beat, with frame_start on the first byte and frame_end on the
// last. Bytes seen outside a frame are dropped.
// Output channel (result_valid / result_stall / result_data): UDP payload
// bytes, plus one status beat (segment_last set) for rejected or short
// frames and one end marker for an empty payload.
// Throughput: one input beat per cycle while byte_stall is low. Each
// byte is parsed by the header state machine in the cycle it is accepted,
// and its result (if any) is registered in the output or skid register.
// A two-entry output stage (output register plus skid register) decouples
// the sides: while the receiver stalls, input beats keep being taken until
// one more result is parked in the skid entry; byte_stall then rises,
// driven from a register only, and drops once the receiver takes a beat.
// Reset clears the parser to idle and empties both output entries.
module udp_payload_extractor #(
    parameter int MAX_FRAME_BYTES = upe_pkg::MAX_FRAME_BYTES
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_stall,
    input  upe_pkg::byte_beat_t   byte_data,
    output logic                  result_valid,
    input  logic                  result_stall,
    output upe_pkg::result_beat_t result_data
);

    logic                  accept;
    logic                  res_valid;
    upe_pkg::result_beat_t res;

    // output register and skid entry
    logic                  out_valid_reg;
    upe_pkg::result_beat_t out_reg;
    logic                  skid_valid_reg;
    upe_pkg::result_beat_t skid_reg;
    logic                  out_free;

    assign byte_stall = skid_valid_reg;
    assign accept     = byte_valid && !skid_valid_reg;

    upe_parser #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .beat      (byte_data),
        .res_valid (res_valid),
        .res       (res)
    );

    // output register can load when empty or when its beat leaves now
    assign out_free = !out_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            // skid full means no beat was accepted, so order is kept
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= res_valid;
            end
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (res_valid)
            begin
                out_reg <= res;
            end
        end
        else if (res_valid)
        begin
            skid_reg <= res;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

endmodule
